// File: hdl/lzid_pkg.sv
`timescale 1ns / 1ps
package lzid_pkg;
	typedef enum logic [1:0] {
		CMD_DATA    = 2'd0,
		CMD_PALETTE = 2'd1,
		CMD_OFFSET  = 2'd2,
		CMD_START   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_MASK    = 2'd0,
		MODE_DIRECT  = 2'd1,
		MODE_PALETTE = 2'd2,
		MODE_SPARE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAL_RD,
		ST_LIT,
		ST_COPY_RD,
		ST_COPY,
		ST_EMIT
	} state_t;

	// configuration register indexes
	localparam bit REG_MODE   = 1'b0;
	localparam bit REG_LENGTH = 1'b1;

	localparam int CHUNK = 8;
	localparam int MAX_TOKEN = 264;
endpackage

// File: hdl/lzid_ram.sv
`timescale 1ns / 1ps
module lzid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/lz_image_decompressor.sv
`timescale 1ns / 1ps
// lz image decompressor: an input item is taken whenever no token is being
// expanded; table writes, flag bytes and the leading bytes of a token do not
// stall intake. a literal of k bytes (one in mask mode, three rgb bytes
// otherwise) keeps intake stalled after its last byte is taken while it writes
// one byte per cycle and then hands the chunk to the output register once that
// is free; palette literals first pass a state for the palette memory read. a
// back reference reads its first source byte, then writes one byte per cycle
// while the chunk is not full (the read of the next source overlaps the write
// of the current byte, with forwarding when the distance is one), stalls to
// hand out every chunk of up to eight bytes, and also stalls while the output
// register stays full. a bad reference yields an empty error item instead.
// history, palette and offset tables are undefined until written; no clearing
// pass is run. WINDOW_BYTES must be a power of two.
module lz_image_decompressor #(
	parameter int WINDOW_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  table_address,
	input  logic [23:0] table_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] chunk_data,
	output logic [3:0]  chunk_bytes,
	output logic        token_last,
	output logic        image_done,
	output logic        error_code
);
	localparam int AW = $clog2(WINDOW_BYTES);

	// configuration
	logic [1:0]  mode_q;
	logic [23:0] length_q;

	// parser state
	lzid_pkg::state_t state_q, state_d;
	logic [7:0]  flag_bits_q;
	logic [3:0]  flags_left_q;
	logic [1:0]  phase_q;
	logic [15:0] partial_q;
	logic [23:0] written_q;

	// token execution
	logic [8:0]  remain_q;      // bytes still to write for this token
	logic [23:0] dist_q;
	logic [63:0] buf_q;
	logic [3:0]  buf_n_q;
	logic [23:0] lit_q;
	logic [1:0]  lit_i_q;

	// output register
	logic        ov_q;
	logic [63:0] od_q;
	logic [3:0]  on_q;
	logic        ol_q, odone_q, oerr_q;

	// memories
	logic          h_we;
	logic [AW-1:0] h_waddr, h_raddr;
	logic [7:0]    h_wdata, h_rdata;
	logic          p_we;
	logic [23:0]   p_rdata;
	logic [15:0]   off_q [16];

	// token decode from the accepted byte
	logic [1:0] mode_e;
	logic       lit;
	logic [1:0] need;
	logic [7:0] t0, t1;
	logic       tok_done;
	logic [23:0] room;
	logic [23:0] c_dist;
	logic [8:0]  c_cnt;
	logic [15:0] num;

	lzid_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);
	// palette index is the first token byte, read in the cycle the token completes
	lzid_ram #(.WIDTH(24), .DEPTH(256)) u_pal (
		.clk(clk), .we(p_we), .waddr(table_address), .wdata(table_value),
		.raddr(t0), .rdata(p_rdata)
	);

	logic accept;
	assign in_ready = (state_q == lzid_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;
	assign p_we = accept && (command == lzid_pkg::CMD_PALETTE);

	always_comb begin
		mode_e = (mode_q == lzid_pkg::MODE_SPARE) ? lzid_pkg::MODE_MASK : mode_q;
		lit = flag_bits_q[7];
		case (mode_e)
			lzid_pkg::MODE_DIRECT:  need = lit ? 2'd3 : 2'd2;
			lzid_pkg::MODE_PALETTE: need = 2'd1;
			default:                need = lit ? 2'd1 : 2'd2;
		endcase
		t0 = (phase_q == 2'd0) ? data_byte : partial_q[7:0];
		t1 = (phase_q == 2'd1) ? data_byte : partial_q[15:8];
		tok_done = ({1'b0, phase_q} + 3'd1) >= {1'b0, need};
		room = (length_q > written_q) ? length_q - written_q : 24'd0;
		num = {t1, t0};
		case (mode_e)
			lzid_pkg::MODE_DIRECT: begin
				c_dist = 24'({12'd0, num[15:4]} + 24'd1) * 24'd3;
				c_cnt  = 9'(({5'd0, num[3:0]} + 9'd1) * 9'd3);
			end
			lzid_pkg::MODE_PALETTE: begin
				c_dist = {8'd0, off_q[t0[3:0]]} * 24'd3;
				c_cnt  = 9'(({5'd0, t0[7:4]} + 9'd2) * 9'd3);
			end
			default: begin
				c_dist = {16'd0, t1} + 24'd1;
				c_cnt  = {1'b0, t0} + 9'd2;
			end
		endcase
	end

	logic [8:0] c_lim;
	logic       c_bad;
	assign c_bad = (c_dist == 24'd0) || (c_dist > written_q)
		|| (c_dist > 24'(WINDOW_BYTES));
	assign c_lim = (room < {15'd0, c_cnt}) ? room[8:0] : c_cnt;

	// copy engine: read source through the registered ram port, then write the byte
	logic [AW-1:0] here;
	logic [AW-1:0] src;
	logic          emit_byte;
	logic [7:0]    byte_v;
	logic          fwd_q;
	logic [7:0]    fwd_byte_q;
	logic          out_free;
	assign here = written_q[AW-1:0];
	assign src = here - dist_q[AW-1:0];
	assign out_free = !ov_q || out_ready;

	always_comb begin
		emit_byte = 1'b0;
		byte_v = 8'd0;
		h_raddr = src;
		case (state_q)
			lzid_pkg::ST_LIT: begin
				emit_byte = (buf_n_q != 4'd8) && (remain_q != 9'd0);
				byte_v = lit_q[8*lit_i_q +: 8];
			end
			lzid_pkg::ST_COPY: begin
				emit_byte = (buf_n_q != 4'd8) && (remain_q != 9'd0);
				byte_v = fwd_q ? fwd_byte_q : h_rdata;
				// look ahead only when the current byte is written this cycle
				h_raddr = emit_byte ? src + AW'(1) : src;
			end
			default: ;
		endcase
		h_we = emit_byte;
		h_waddr = here;
		h_wdata = byte_v;
	end

	// flush a chunk when full or token finished, once the output register is free
	logic flush;
	assign flush = (state_q == lzid_pkg::ST_LIT || state_q == lzid_pkg::ST_COPY)
		&& (buf_n_q == 4'd8 || remain_q == 9'd0) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lzid_pkg::ST_IDLE:
				if (accept && command == lzid_pkg::CMD_DATA && room != 24'd0
					&& flags_left_q != 4'd0 && tok_done) begin
					if (lit) state_d = (mode_e == lzid_pkg::MODE_PALETTE)
						? lzid_pkg::ST_PAL_RD : lzid_pkg::ST_LIT;
					else if (c_bad) state_d = lzid_pkg::ST_EMIT;
					else state_d = lzid_pkg::ST_COPY_RD;
				end
			lzid_pkg::ST_PAL_RD:  state_d = lzid_pkg::ST_LIT;
			lzid_pkg::ST_COPY_RD: state_d = lzid_pkg::ST_COPY;
			lzid_pkg::ST_LIT, lzid_pkg::ST_COPY:
				if (flush && remain_q == 9'd0) state_d = lzid_pkg::ST_IDLE;
			lzid_pkg::ST_EMIT:
				if (out_free) state_d = lzid_pkg::ST_IDLE;
			default: state_d = lzid_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lzid_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// offset table, small and read at one decoded place
	always_ff @(posedge clk) begin
		if (accept && command == lzid_pkg::CMD_OFFSET && table_address < 8'd16)
			off_q[table_address[3:0]] <= table_value[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lzid_pkg::MODE_MASK;
			length_q <= 24'd0;
			flag_bits_q <= 8'd0;
			flags_left_q <= 4'd0;
			phase_q <= 2'd0;
			partial_q <= 16'd0;
			written_q <= 24'd0;
			ov_q <= 1'b0;
			remain_q <= 9'd0;
			dist_q <= 24'd0;
			buf_q <= 64'd0;
			buf_n_q <= 4'd0;
			lit_q <= 24'd0;
			lit_i_q <= 2'd0;
			fwd_q <= 1'b0;
			fwd_byte_q <= 8'd0;
			od_q <= 64'd0;
			on_q <= 4'd0;
			ol_q <= 1'b0;
			odone_q <= 1'b0;
			oerr_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lzid_pkg::REG_MODE) mode_q <= cfg_data[1:0];
				else length_q <= cfg_data;
			end
			if (ov_q && out_ready) ov_q <= 1'b0;

			if (accept) begin
				if (command == lzid_pkg::CMD_START) begin
					flag_bits_q <= 8'd0;
					flags_left_q <= 4'd0;
					phase_q <= 2'd0;
					partial_q <= 16'd0;
					written_q <= 24'd0;
				end else if (command == lzid_pkg::CMD_DATA && room != 24'd0) begin
					if (flags_left_q == 4'd0) begin
						flag_bits_q <= data_byte;
						flags_left_q <= 4'd8;
					end else if (!tok_done) begin
						if (phase_q == 2'd0) partial_q <= {8'd0, data_byte};
						else partial_q <= {data_byte, partial_q[7:0]};
						phase_q <= phase_q + 2'd1;
					end else begin
						flag_bits_q <= {flag_bits_q[6:0], 1'b0};
						flags_left_q <= flags_left_q - 4'd1;
						phase_q <= 2'd0;
						partial_q <= 16'd0;
						buf_n_q <= 4'd0;
						lit_i_q <= 2'd0;
						fwd_q <= 1'b0;
						dist_q <= c_dist;
						if (lit) begin
							case (mode_e)
								lzid_pkg::MODE_DIRECT: begin
									lit_q <= {data_byte, t1, t0};
									remain_q <= (room < 24'd3) ? room[8:0] : 9'd3;
								end
								lzid_pkg::MODE_PALETTE:
									remain_q <= (room < 24'd3) ? room[8:0] : 9'd3;
								default: begin
									// first token byte, also after a mode change mid token
									lit_q <= {16'd0, t0};
									remain_q <= 9'd1;
								end
							endcase
						end else begin
							remain_q <= c_lim;
						end
					end
				end
			end

			if (state_q == lzid_pkg::ST_PAL_RD) lit_q <= p_rdata;

			if (emit_byte) begin
				written_q <= written_q + 24'd1;
				remain_q <= remain_q - 9'd1;
				buf_n_q <= buf_n_q + 4'd1;
				buf_q[8*buf_n_q[2:0] +: 8] <= byte_v;
				lit_i_q <= lit_i_q + 2'd1;
				// next source is the byte written now when distance is one
				fwd_q <= (dist_q == 24'd1);
				fwd_byte_q <= byte_v;
			end else if (state_q == lzid_pkg::ST_COPY) begin
				fwd_q <= 1'b0;
			end

			if (flush) begin
				ov_q <= 1'b1;
				od_q <= buf_q & ({64{1'b1}} >> (7'd64 - {buf_n_q, 3'd0}));
				on_q <= buf_n_q;
				ol_q <= (remain_q == 9'd0);
				// done reflects the count once the whole token is written
				odone_q <= ((written_q + {15'd0, remain_q}) >= length_q);
				oerr_q <= 1'b0;
				buf_n_q <= 4'd0;
			end
			if (state_q == lzid_pkg::ST_EMIT && out_free) begin
				ov_q <= 1'b1;
				od_q <= 64'd0;
				on_q <= 4'd0;
				ol_q <= 1'b1;
				odone_q <= (written_q >= length_q);
				oerr_q <= 1'b1;
			end
		end
	end

	// copy state stalls while the chunk is full; source read is re-issued
	// from the unchanged write pointer so a stall resumes cleanly

	assign out_valid = ov_q;
	assign chunk_data = od_q;
	assign chunk_bytes = on_q;
	assign token_last = ol_q;
	assign image_done = odone_q;
	assign error_code = oerr_q;

	a_chunk_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunk_bytes <= 4'd8)
		else $error("chunk over eight bytes");
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code) |-> (chunk_bytes == 4'd0 && token_last))
		else $error("error item carries bytes");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(chunk_data)))
		else $error("output item changed while stalled");
	a_no_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lzid_pkg::ST_COPY) |-> !in_ready)
		else $error("intake during copy");
endmodule
